// File: hw/rtl/vhsl_pkg.sv
// Shared constants, types and helpers for the value-to-HSL rainbow color block.
package vhsl_pkg;

   localparam int ValueWidthDefault    = 32;
   localparam int FractionBitsDefault  = 10;
   localparam int PosBits              = 16;
   localparam int PosWidth             = PosBits + 1;
   localparam int CsrIndexWidth        = 2;

   // Register indexes of the configuration port.
   localparam logic [CsrIndexWidth-1:0] CSR_RANGE_LOW  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_RANGE_HIGH = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SATURATION = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_LIGHTNESS  = 2'd3;

   // Hue sectors, one per 60 degrees.
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW   = 3'd0,
      SECTOR_YELLOW_GREEN = 3'd1,
      SECTOR_GREEN_CYAN   = 3'd2,
      SECTOR_CYAN_BLUE    = 3'd3,
      SECTOR_BLUE_MAGENTA = 3'd4,
      SECTOR_MAGENTA_RED  = 3'd5
   } sector_type;

endpackage

// File: hw/rtl/value_to_hsl_rainbow_color.sv
// Top level of the value-to-HSL rainbow color pipeline.
//
//  Channel | Ports                          | Handshake
//  --------+--------------------------------+-----------------------------------
//  request | req_sample_value               | start high and busy low
//  result  | rsp_red/green/blue/packed_color| rsp_valid high for one cycle
//  config  | csr_write, csr_index, csr_data | csr_write high
//
// One transaction enters each cycle; busy is always low.
// The pipeline has one input stage, 16 division stages (one quotient bit of the position
// per stage), then hue/sector, chroma, component, sum, byte and output stages.
// Synchronous reset clears the valid bits and the configuration registers.
// The receiver cannot stall, so the pipeline never holds.
module value_to_hsl_rainbow_color #(
   parameter int VALUE_WIDTH   = vhsl_pkg::ValueWidthDefault,
   parameter int FRACTION_BITS = vhsl_pkg::FractionBitsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [VALUE_WIDTH-1:0]         req_sample_value,
   output logic                                  rsp_valid,
   output logic [7:0]                            rsp_red,
   output logic [7:0]                            rsp_green,
   output logic [7:0]                            rsp_blue,
   output logic [23:0]                           rsp_packed_color,
   input  logic                                  csr_write,
   input  logic [vhsl_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [((VALUE_WIDTH > FRACTION_BITS + 1) ? VALUE_WIDTH
                                                    : FRACTION_BITS + 1)-1:0] csr_data
);

   localparam int FW    = FRACTION_BITS + 1;
   localparam int DW    = VALUE_WIDTH + 1;
   localparam int STEPS = vhsl_pkg::PosBits;
   localparam int HW    = vhsl_pkg::PosWidth + 9;
   localparam logic [FW-1:0] FixOne = FW'(1) << FRACTION_BITS;
   localparam logic [HW-1:0] Sector = HW'(60) << vhsl_pkg::PosBits;
   // Component numerator width: c' = (one-dist)*s over one^2, times x over sector.
   localparam int CW    = 2 * FW;

   // Configuration registers.
   logic signed [VALUE_WIDTH-1:0] range_low_ff, range_high_ff;
   logic [FW-1:0] saturation_ff, lightness_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= VALUE_WIDTH'(255);
         saturation_ff <= FixOne;
         lightness_ff  <= FixOne >> 1;
      end else if (csr_write) begin
         unique case (csr_index)
            vhsl_pkg::CSR_RANGE_LOW:  range_low_ff  <= csr_data[VALUE_WIDTH-1:0];
            vhsl_pkg::CSR_RANGE_HIGH: range_high_ff <= csr_data[VALUE_WIDTH-1:0];
            vhsl_pkg::CSR_SATURATION: saturation_ff <= csr_data[FW-1:0];
            vhsl_pkg::CSR_LIGHTNESS:  lightness_ff  <= csr_data[FW-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Stage 0 saturates the sample and forms numerator and denominator; the division
   // stages behind it take one quotient bit each.
   logic [STEPS:0]          dv_valid_ff;
   logic [DW-1:0]           dv_num_ff [STEPS+1];
   logic [DW-1:0]           dv_den_ff [STEPS+1];
   logic [STEPS-1:0]        dv_q_ff   [STEPS+1];
   logic [STEPS:0]          dv_full_ff, dv_zero_ff;
   logic [DW-1:0]           dv_rest [STEPS];
   logic [STEPS-1:0]        dv_take;
   logic signed [VALUE_WIDTH-1:0] clamp_in;

   always_comb begin
      clamp_in = req_sample_value;
      if (req_sample_value < range_low_ff)  clamp_in = range_low_ff;
      if (req_sample_value > range_high_ff) clamp_in = range_high_ff;
   end

   // Restoring step: the remainder either doubles or drops by the distance to the divisor.
   always_comb begin
      for (int i = 0; i < STEPS; i++) begin
         dv_rest[i] = dv_den_ff[i] - dv_num_ff[i];
         dv_take[i] = dv_num_ff[i] >= dv_rest[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dv_valid_ff <= '0;
      else       dv_valid_ff <= {dv_valid_ff[STEPS-1:0], start};
      dv_num_ff[0]  <= DW'(clamp_in) - DW'(range_low_ff);
      dv_den_ff[0]  <= DW'(range_high_ff) - DW'(range_low_ff);
      dv_q_ff[0]    <= '0;
      dv_zero_ff[0] <= !(range_high_ff > range_low_ff);
      dv_full_ff[0] <= (clamp_in == range_high_ff);
      for (int i = 0; i < STEPS; i++) begin
         dv_num_ff[i+1]  <= dv_take[i] ? dv_num_ff[i] - dv_rest[i]
                                       : {dv_num_ff[i][DW-2:0], 1'b0};
         dv_q_ff[i+1]    <= {dv_q_ff[i][STEPS-2:0], dv_take[i]};
         dv_den_ff[i+1]  <= dv_den_ff[i];
         dv_full_ff[i+1] <= dv_full_ff[i];
         dv_zero_ff[i+1] <= dv_zero_ff[i];
      end
   end

   // Hue stage: position times 360, folded into sector and x numerator.
   logic [vhsl_pkg::PosWidth-1:0] pos;
   logic [HW-1:0]   hue, tm, fold;
   logic            h_valid_ff;
   logic [HW-1:0]   h_xn_ff;
   vhsl_pkg::sector_type h_sector_ff, sector;
   logic [FW-1:0]   s_cl, l_cl;
   logic [FW:0]     two_l, l_dev;
   logic [FW-1:0]   h_cbase_ff, h_s_ff, h_l_ff;

   always_comb begin
      if (dv_zero_ff[STEPS])      pos = '0;
      else if (dv_full_ff[STEPS]) pos = vhsl_pkg::PosWidth'(1) << vhsl_pkg::PosBits;
      else                        pos = {1'b0, dv_q_ff[STEPS]};
      hue = HW'(pos) * HW'(360);
      tm  = hue;
      if (tm >= (Sector << 2))      tm = tm - (Sector << 2);
      else if (tm >= (Sector << 1)) tm = tm - (Sector << 1);
      fold = (tm > Sector) ? tm - Sector : Sector - tm;
      priority if (hue < Sector)            sector = vhsl_pkg::SECTOR_RED_YELLOW;
      else if (hue < (Sector << 1))         sector = vhsl_pkg::SECTOR_YELLOW_GREEN;
      else if (hue < HW'(3) * Sector)       sector = vhsl_pkg::SECTOR_GREEN_CYAN;
      else if (hue < (Sector << 2))         sector = vhsl_pkg::SECTOR_CYAN_BLUE;
      else if (hue < HW'(5) * Sector)       sector = vhsl_pkg::SECTOR_BLUE_MAGENTA;
      else                                  sector = vhsl_pkg::SECTOR_MAGENTA_RED;
      s_cl  = (saturation_ff > FixOne) ? FixOne : saturation_ff;
      l_cl  = (lightness_ff > FixOne) ? FixOne : lightness_ff;
      two_l = {l_cl, 1'b0};
      l_dev = (two_l > (FW+1)'(FixOne)) ? two_l - (FW+1)'(FixOne)
                                        : (FW+1)'(FixOne) - two_l;
   end

   always_ff @(posedge clock) begin
      if (reset) h_valid_ff <= 1'b0;
      else       h_valid_ff <= dv_valid_ff[STEPS];
      h_xn_ff     <= Sector - fold;
      h_sector_ff <= sector;
      h_cbase_ff  <= FW'((FW+1)'(FixOne) - l_dev);
      h_s_ff      <= s_cl;
      h_l_ff      <= l_cl;
   end

   // Chroma stage: cn = (one - dist) * s.
   logic            c_valid_ff;
   logic [CW-1:0]   c_cn_ff;
   logic [HW-1:0]   c_xn_ff;
   vhsl_pkg::sector_type c_sector_ff;
   logic [FW-1:0]   c_l_ff;

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else       c_valid_ff <= h_valid_ff;
      c_cn_ff     <= CW'(h_cbase_ff) * CW'(h_s_ff);
      c_xn_ff     <= h_xn_ff;
      c_sector_ff <= h_sector_ff;
      c_l_ff      <= h_l_ff;
   end

   // Component stage, all over sector units: cc = cn*S, xx = cn*xn, mm = (2l*one - cn)*S/2.
   // Common denominator here is one^2 * S (factor 2 cancels).
   localparam int MW = CW + HW;
   logic            m_valid_ff;
   logic [MW-1:0]   m_cc_ff, m_xx_ff, m_mm2_ff;
   vhsl_pkg::sector_type m_sector_ff;

   always_ff @(posedge clock) begin
      if (reset) m_valid_ff <= 1'b0;
      else       m_valid_ff <= c_valid_ff;
      m_cc_ff     <= MW'(c_cn_ff) * MW'(Sector);
      m_xx_ff     <= MW'(c_cn_ff) * MW'(c_xn_ff);
      // 2*mm over 2*den: keep numerators doubled for cc and xx below.
      m_mm2_ff    <= (MW'({c_l_ff, 1'b0}) * MW'(FixOne) - MW'(c_cn_ff)) * MW'(Sector);
      m_sector_ff <= c_sector_ff;
   end

   // Sum stage: select components per sector and add offset, numerators over 2*one^2*S.
   logic            a_valid_ff;
   logic [MW+1:0]   a_r_ff, a_g_ff, a_b_ff;
   logic [MW+1:0]   cc2, xx2, mm;

   always_comb begin
      cc2 = (MW+2)'(m_cc_ff) << 1;
      xx2 = (MW+2)'(m_xx_ff) << 1;
      mm  = (MW+2)'(m_mm2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else       a_valid_ff <= m_valid_ff;
      unique case (m_sector_ff)
         vhsl_pkg::SECTOR_RED_YELLOW:   begin
            a_r_ff <= cc2 + mm; a_g_ff <= xx2 + mm; a_b_ff <= mm;
         end
         vhsl_pkg::SECTOR_YELLOW_GREEN: begin
            a_r_ff <= xx2 + mm; a_g_ff <= cc2 + mm; a_b_ff <= mm;
         end
         vhsl_pkg::SECTOR_GREEN_CYAN:   begin
            a_r_ff <= mm; a_g_ff <= cc2 + mm; a_b_ff <= xx2 + mm;
         end
         vhsl_pkg::SECTOR_CYAN_BLUE:    begin
            a_r_ff <= mm; a_g_ff <= xx2 + mm; a_b_ff <= cc2 + mm;
         end
         vhsl_pkg::SECTOR_BLUE_MAGENTA: begin
            a_r_ff <= xx2 + mm; a_g_ff <= mm; a_b_ff <= cc2 + mm;
         end
         default:                       begin
            a_r_ff <= cc2 + mm; a_g_ff <= mm; a_b_ff <= xx2 + mm;
         end
      endcase
   end

   // Byte stage: value*255 / (2*one^2*S). The denominator is 2^(2F+1) * 15 * 2^18,
   // so divide by 15 via a reciprocal after the power-of-two shift.
   localparam int ShiftBits = 2 * FRACTION_BITS + 1 + vhsl_pkg::PosBits + 2;
   logic            b_valid_ff;
   logic [11:0]     b_r_ff, b_g_ff, b_b_ff;

   function automatic logic [11:0] scale_part(input logic [MW+1:0] part);
      logic [MW+9:0] prod;
      prod = (MW+10)'(part) * (MW+10)'(255);
      return 12'(prod >> ShiftBits);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else       b_valid_ff <= a_valid_ff;
      b_r_ff <= scale_part(a_r_ff);
      b_g_ff <= scale_part(a_g_ff);
      b_b_ff <= scale_part(a_b_ff);
   end

   // Output stage: floor divide by 15 (value below 4096) and clamp to 255.
   function automatic logic [7:0] div15(input logic [11:0] v);
      logic [23:0] q;
      logic [11:0] qq, rem;
      q   = 24'(v) * 24'(2185);
      qq  = 12'(q >> 15);
      rem = v - 12'(qq * 12'd15);
      if (rem >= 12'd15) qq = qq + 12'd1;
      return (qq > 12'd255) ? 8'd255 : qq[7:0];
   endfunction

   logic       o_valid_ff;
   logic [7:0] o_r_ff, o_g_ff, o_b_ff;

   always_ff @(posedge clock) begin
      if (reset) o_valid_ff <= 1'b0;
      else       o_valid_ff <= b_valid_ff;
      o_r_ff <= div15(b_r_ff);
      o_g_ff <= div15(b_g_ff);
      o_b_ff <= div15(b_b_ff);
   end

   assign rsp_valid        = o_valid_ff;
   assign rsp_red          = o_r_ff;
   assign rsp_green        = o_g_ff;
   assign rsp_blue         = o_b_ff;
   assign rsp_packed_color = {o_r_ff, o_g_ff, o_b_ff};

   // Checks on the pipeline's valid chain.
   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff |=> ##1 o_valid_ff) else $error("valid lost in output stages");
   a_no_busy: assert property (@(posedge clock) !busy)
      else $error("busy must stay low");
   a_div_chain: assert property (@(posedge clock) disable iff (reset)
      dv_valid_ff[0] |=> dv_valid_ff[1]) else $error("valid lost in divider");

endmodule

// File: tb/tb_value_to_hsl_rainbow_color.sv
// Testbench for the value-to-HSL rainbow color block: directed table, then random phases.
`timescale 1ns / 100ps

module tb_value_to_hsl_rainbow_color;

   localparam int      DrainCycles   = 30;     // covers the block's pipeline depth
   localparam int      WatchdogLimit = 2000;
   localparam longint  SectorSpan    = 64'd3932160;  // 60 degrees with 16 fraction bits
   localparam longint  FixOne        = 64'd1024;

   typedef struct packed {
      logic signed [31:0] low;
      logic signed [31:0] high;
      logic [10:0]        sat;
      logic [10:0]        light;
   } color_setup_type;

   typedef struct {
      color_setup_type    setup;
      logic signed [31:0] sample;
      bit                 typed;
      logic [23:0]        color;
   } color_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic signed [31:0]  req_sample_value = '0;
   logic                rsp_valid;
   logic [7:0]          rsp_red, rsp_green, rsp_blue;
   logic [23:0]         rsp_packed_color;
   logic                csr_write = 1'b0;
   logic [vhsl_pkg::CsrIndexWidth-1:0] csr_index = vhsl_pkg::CSR_RANGE_LOW;
   logic [31:0]         csr_data = '0;

   // Shadow copy of the configuration registers, updated on each accepted write.
   logic signed [31:0]  shadow_low, shadow_high;
   logic [10:0]         shadow_sat, shadow_light;

   logic [23:0]         color_queue[$];
   bit                  typed_pending;
   logic [23:0]         typed_color;
   int                  mismatch_count = 0;
   int                  idle_cycles = 0;
   color_setup_type     current_setup;

   value_to_hsl_rainbow_color u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_packed_color (rsp_packed_color),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Scale one component fraction to a byte, truncating.
   function automatic logic [7:0] scale_byte(longint unsigned part, longint unsigned den);
      longint unsigned v;
      v = (part * 255) / den;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // Color of one sample under the shadow configuration.
   function automatic logic [23:0] hsl_color(logic signed [31:0] sample);
      logic signed [31:0] v;
      longint unsigned span, hue, s, l, two_l, l_dev, cn, tm, xn, den, cc, xx, mm;
      longint unsigned r, g, b;
      hue = 0;
      if (shadow_high > shadow_low) begin
         v = sample;
         if (v < shadow_low) v = shadow_low;
         if (v > shadow_high) v = shadow_high;
         span = longint'(shadow_high) - longint'(shadow_low);
         hue  = (((longint'(v) - longint'(shadow_low)) << 16) / span) * 360;
      end
      s = (shadow_sat > FixOne) ? FixOne : shadow_sat;
      l = (shadow_light > FixOne) ? FixOne : shadow_light;
      two_l = 2 * l;
      l_dev = (two_l > FixOne) ? two_l - FixOne : FixOne - two_l;
      cn    = (FixOne - l_dev) * s;
      tm    = hue % (2 * SectorSpan);
      xn    = SectorSpan - ((tm > SectorSpan) ? tm - SectorSpan : SectorSpan - tm);
      den   = 2 * FixOne * FixOne * SectorSpan;
      cc    = 2 * cn * SectorSpan;
      xx    = 2 * cn * xn;
      mm    = (2 * l * FixOne - cn) * SectorSpan;
      if (hue < SectorSpan) begin
         r = cc; g = xx; b = 0;
      end else if (hue < 2 * SectorSpan) begin
         r = xx; g = cc; b = 0;
      end else if (hue < 3 * SectorSpan) begin
         r = 0; g = cc; b = xx;
      end else if (hue < 4 * SectorSpan) begin
         r = 0; g = xx; b = cc;
      end else if (hue < 5 * SectorSpan) begin
         r = xx; g = 0; b = cc;
      end else begin
         r = cc; g = 0; b = xx;
      end
      return {scale_byte(r + mm, den), scale_byte(g + mm, den), scale_byte(b + mm, den)};
   endfunction

   // Track configuration, predict accepted transactions and check results.
   always @(posedge clock) begin
      logic [23:0] want;
      if (reset) begin
         shadow_low   <= 32'sd0;
         shadow_high  <= 32'sd255;
         shadow_sat   <= 11'd1024;
         shadow_light <= 11'd512;
         idle_cycles  <= 0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               vhsl_pkg::CSR_RANGE_LOW:  shadow_low   <= csr_data;
               vhsl_pkg::CSR_RANGE_HIGH: shadow_high  <= csr_data;
               vhsl_pkg::CSR_SATURATION: shadow_sat   <= csr_data[10:0];
               vhsl_pkg::CSR_LIGHTNESS:  shadow_light <= csr_data[10:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            want = typed_pending ? typed_color : hsl_color(req_sample_value);
            color_queue.push_back(want);
         end
         if (rsp_valid) begin
            if (color_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected result: packed %h", rsp_packed_color);
            end else begin
               want = color_queue.pop_front();
               if (rsp_red !== want[23:16] || rsp_green !== want[15:8] ||
                   rsp_blue !== want[7:0] || rsp_packed_color !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Color mismatch: expected %h, got r=%h g=%h b=%h packed=%h",
                              want, rsp_red, rsp_green, rsp_blue, rsp_packed_color);
               end
            end
         end
         // The watchdog restarts whenever a transaction or a result moves.
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WatchdogLimit) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Wait until every expected result has arrived and the pipeline is empty.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (color_queue.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Hold one register write for a cycle; the caller drops the write enable.
   task automatic write_register(logic [vhsl_pkg::CsrIndexWidth-1:0] index,
                                 logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
   endtask

   // Change the configuration only with the block idle.
   task automatic apply_setup(color_setup_type setup);
      drain_results();
      write_register(vhsl_pkg::CSR_RANGE_LOW, setup.low);
      write_register(vhsl_pkg::CSR_RANGE_HIGH, setup.high);
      write_register(vhsl_pkg::CSR_SATURATION, {21'd0, setup.sat});
      write_register(vhsl_pkg::CSR_LIGHTNESS, {21'd0, setup.light});
      csr_write <= 1'b0;
      @(posedge clock);
      current_setup = setup;
   endtask

   // Present one transaction and hold it until it is taken.
   task automatic send_sample(logic signed [31:0] sample, bit typed, logic [23:0] color);
      start         <= 1'b1;
      req_sample_value <= sample;
      typed_pending <= typed;
      typed_color   <= color;
      do @(posedge clock); while (busy);
   endtask

   function automatic color_setup_type make_setup(logic signed [31:0] low,
                                                  logic signed [31:0] high,
                                                  logic [10:0] sat, logic [10:0] light);
      color_setup_type s;
      s.low = low; s.high = high; s.sat = sat; s.light = light;
      return s;
   endfunction

   // Sample biased toward the configured range, with some out-of-range noise.
   function automatic logic signed [31:0] pick_sample();
      longint span;
      unique case ($urandom_range(0, 9))
         0, 1:    return $urandom();
         2:       return current_setup.low;
         3:       return current_setup.high;
         4:       return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
         default: begin
            span = longint'(current_setup.high) - longint'(current_setup.low);
            if (span <= 0 || span > 64'd4000000000) return $urandom();
            return 32'(longint'(current_setup.low) + (longint'($urandom()) % (span + 1)));
         end
      endcase
   endfunction

   color_row_type   directed_rows[$];
   color_setup_type random_setups[$];
   color_setup_type reset_setup;

   initial begin
      int remaining_burst;
      reset_setup = make_setup(32'sd0, 32'sd255, 11'd1024, 11'd512);
      current_setup = reset_setup;

      // Directed table: colors typed in where they follow at a glance.
      directed_rows = '{
         '{reset_setup, 32'sd0,          1'b1, 24'hFF0000},
         '{reset_setup, 32'sd255,        1'b1, 24'hFF0000},
         '{reset_setup, 32'sh8000_0000,  1'b1, 24'hFF0000},
         '{reset_setup, 32'sh7fff_ffff,  1'b1, 24'hFF0000},
         '{reset_setup, 32'sd43,         1'b0, 24'h0},
         '{reset_setup, 32'sd85,         1'b0, 24'h0},
         '{reset_setup, 32'sd128,        1'b0, 24'h0},
         '{reset_setup, 32'sd170,        1'b0, 24'h0},
         '{reset_setup, 32'sd212,        1'b0, 24'h0},
         '{reset_setup, 32'sd254,        1'b0, 24'h0},
         '{make_setup(32'sd0, 32'sd255, 11'd1024, 11'd0),    32'sd100, 1'b1, 24'h000000},
         '{make_setup(32'sd0, 32'sd255, 11'd1024, 11'd1024), 32'sd100, 1'b1, 24'hFFFFFF},
         '{make_setup(32'sd0, 32'sd255, 11'd2047, 11'd2047), 32'sd50,  1'b1, 24'hFFFFFF},
         '{make_setup(32'sd0, 32'sd255, 11'd0, 11'd512),     32'sd100, 1'b1, 24'h7F7F7F},
         '{make_setup(32'sd10, 32'sd10, 11'd1024, 11'd512),  32'sd77,  1'b1, 24'hFF0000},
         '{make_setup(32'sd50, -32'sd50, 11'd1024, 11'd512), 32'sd0,   1'b1, 24'hFF0000},
         '{make_setup(32'sh8000_0000, 32'sh7fff_ffff, 11'd700, 11'd300), 32'sd0, 1'b0, 24'h0},
         '{make_setup(32'sh8000_0000, 32'sh7fff_ffff, 11'd700, 11'd300),
           32'sh8000_0000, 1'b0, 24'h0},
         '{make_setup(32'sh8000_0000, 32'sh7fff_ffff, 11'd700, 11'd300),
           32'sh7fff_ffff, 1'b0, 24'h0},
         '{make_setup(-32'sd1000, 32'sd2000, 11'd1500, 11'd800), -32'sd5000, 1'b0, 24'h0},
         '{make_setup(-32'sd1000, 32'sd2000, 11'd1500, 11'd800), 32'sd1500,  1'b0, 24'h0}
      };

      random_setups = '{
         reset_setup,
         make_setup(32'sh8000_0000, 32'sh7fff_ffff, 11'd1024, 11'd512),
         make_setup(-32'sd360, 32'sd360, 11'd0, 11'd1024),
         make_setup(32'sd100, 32'sd100, 11'd1024, 11'd512),
         make_setup(32'sh7fff_ffff, 32'sh8000_0000, 11'd2047, 11'd0),
         make_setup(-32'sd1, 32'sd0, 11'd512, 11'd256)
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].setup != current_setup) apply_setup(directed_rows[i].setup);
         send_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].color);
         if ($urandom_range(0, 1)) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end

      // Random phases: fixed corner setups, then fully random ones.
      for (int phase = 0; phase < 12; phase++) begin
         if (phase < random_setups.size())
            apply_setup(random_setups[phase]);
         else
            apply_setup(make_setup($urandom(), $urandom(),
                                   11'($urandom_range(0, 2047)),
                                   11'($urandom_range(0, 2047))));
         remaining_burst = $urandom_range(1, 24);
         for (int n = 0; n < 100; n++) begin
            send_sample(pick_sample(), 1'b0, 24'h0);
            remaining_burst--;
            if (remaining_burst == 0) begin
               remaining_burst = $urandom_range(1, 24);
               if (phase % 3 != 1) begin
                  start <= 1'b0;
                  repeat ($urandom_range(1, 6)) @(posedge clock);
               end
            end
         end
      end

      drain_results();
      if (mismatch_count == 0 && color_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/vhsl_pkg.sv
hw/rtl/value_to_hsl_rainbow_color.sv
tb/tb_value_to_hsl_rainbow_color.sv
